// ===== rtl/csp_pkg.sv =====
package csp_pkg;

  // configuration register indexes
  localparam logic CFG_RADIUS      = 1'b0;
  localparam logic CFG_HALF_LENGTH = 1'b1;

  // reset values, 1.0 in q16.16
  localparam logic [30:0] RADIUS_RESET      = 31'd65536;
  localparam logic [30:0] HALF_LENGTH_RESET = 31'd65536;

  // 1.0 in q1.30
  localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;

  // one root bit per step, one quotient bit per step
  localparam int unsigned ISQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS   = 31;

  // pipeline stage map
  localparam int unsigned ST_SQRT0     = 2;
  localparam int unsigned ST_ENDPT     = 5;
  localparam int unsigned ST_SQRT_LAST = ST_SQRT0 + ISQRT_STEPS - 1;
  localparam int unsigned ST_DIVIN     = ST_SQRT_LAST + 1;
  localparam int unsigned ST_DIV0      = ST_DIVIN + 1;
  localparam int unsigned ST_DIV_LAST  = ST_DIV0 + DIV_STEPS - 1;
  localparam int unsigned ST_OUT       = ST_DIV_LAST + 1;
  localparam int unsigned NSTAGE       = ST_OUT + 1;

endpackage

// ===== rtl/csp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module csp_isqrt (
  input  logic                               clk,
  input  logic [csp_pkg::ISQRT_STEPS-1:0]    en,
  input  logic [63:0]                        radicand,
  output logic [31:0]                        root
);

  localparam int unsigned N = csp_pkg::ISQRT_STEPS;

  logic [63:0] rem_q  [N];
  logic [63:0] res_q  [N];
  logic [63:0] rem_in [N];
  logic [63:0] res_in [N];

  assign rem_in[0] = radicand;
  assign res_in[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = res_in[k] + BIT;

    if (k > 0) begin : g_link
      assign rem_in[k] = rem_q[k-1];
      assign res_in[k] = res_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (rem_in[k] >= trial) begin
          rem_q[k] <= rem_in[k] - trial;
          res_q[k] <= (res_in[k] >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in[k];
          res_q[k] <= res_in[k] >> 1;
        end
      end
    end
  end

  assign root = res_q[N-1][31:0];

endmodule

// ===== rtl/csp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, msb first
// quotient must fit in the quotient width (num < den * 2^31)
module csp_div (
  input  logic                             clk,
  input  logic [csp_pkg::DIV_STEPS-1:0]    en,
  input  logic [61:0]                      num,
  input  logic [31:0]                      den,
  output logic [csp_pkg::DIV_STEPS-1:0]    quo
);

  localparam int unsigned N = csp_pkg::DIV_STEPS;

  logic [31:0]  rem_q  [N];
  logic [31:0]  den_q  [N];
  logic [30:0]  lo_q   [N];
  logic [N-1:0] quo_q  [N];
  logic [31:0]  rem_in [N];
  logic [31:0]  den_in [N];
  logic [30:0]  lo_in  [N];
  logic [N-1:0] quo_in [N];

  assign rem_in[0] = {1'b0, num[61:31]};
  assign den_in[0] = den;
  assign lo_in[0]  = num[30:0];
  assign quo_in[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int unsigned J = N - 1 - k;
    logic [32:0] part;
    logic        take;

    assign part = {rem_in[k], lo_in[k][J]};
    assign take = part >= {1'b0, den_in[k]};

    if (k > 0) begin : g_link
      assign rem_in[k] = rem_q[k-1];
      assign den_in[k] = den_q[k-1];
      assign lo_in[k]  = lo_q[k-1];
      assign quo_in[k] = quo_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k] <= take ? 32'(part - {1'b0, den_in[k]}) : 32'(part);
        den_q[k] <= den_in[k];
        lo_q[k]  <= lo_in[k];
        quo_q[k] <= {quo_in[k][N-2:0], take};
      end
    end
  end

  assign quo = quo_q[N-1];

endmodule

// ===== rtl/capsule_support_point_core.sv =====
// path: a request passes through two front stages, 32 square root stages, a dividend stage,
//   31 divider stages and the output register
// throughput: one request per cycle unless out_ready stalls the pipeline; the 32-stage square root
//   and the 31-stage divider lanes each take one new operand per cycle
// stalls: each stage holds while the next one is full and stalled, bubbles close up
// reset: synchronous, clears all stage valid bits and sets radius and half_length to 1.0
module capsule_support_point_core (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] quat_w,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic               zero_direction
);

  localparam int unsigned NSTAGE       = csp_pkg::NSTAGE;
  localparam int unsigned ST_SQRT0     = csp_pkg::ST_SQRT0;
  localparam int unsigned ST_SQRT_LAST = csp_pkg::ST_SQRT_LAST;
  localparam int unsigned ST_ENDPT     = csp_pkg::ST_ENDPT;
  localparam int unsigned ST_DIVIN     = csp_pkg::ST_DIVIN;
  localparam int unsigned ST_DIV0      = csp_pkg::ST_DIV0;
  localparam int unsigned ST_DIV_LAST  = csp_pkg::ST_DIV_LAST;
  localparam int unsigned ST_OUT       = csp_pkg::ST_OUT;

  // request data that rides along the front stages
  typedef struct packed {
    logic [2:0][31:0] dir;
    logic [2:0][31:0] pos;
    logic             core;
    logic             zero;
  } front_t;

  // chosen endpoint and what the radius offset needs later on
  typedef struct packed {
    logic [2:0][32:0] pt;
    logic [2:0][31:0] absd;
    logic [2:0]       dneg;
    logic             core;
    logic             zero;
  } side_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] a);
    return a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [63:0] a);
    priority if (a > csp_pkg::Q30_ONE) return 32'(csp_pkg::Q30_ONE);
    else if (a < -csp_pkg::Q30_ONE)    return 32'(-csp_pkg::Q30_ONE);
    else                               return 32'(a);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] a);
    priority if (a > 34'sd2147483647)   return 32'sh7fffffff;
    else if (a < -34'sd2147483648)      return 32'sh80000000;
    else                                return 32'(a);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [30:0] radius;
  logic [30:0] half_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= csp_pkg::RADIUS_RESET;
      half_length <= csp_pkg::HALF_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        csp_pkg::CFG_RADIUS:      radius      <= cfg_data;
        csp_pkg::CFG_HALF_LENGTH: half_length <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage valid bits and per-stage load enables
  // a stage loads when it is empty or its content moves on this cycle
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

  // ---------------------------------------------------------------------------
  // stage 0: quaternion products and direction squares
  // ---------------------------------------------------------------------------
  logic [31:0]        absd_in [3];
  logic signed [63:0] s0_pxz, s0_pwy, s0_pyz, s0_pwx, s0_pxx, s0_pyy;
  logic [63:0]        s0_sq [3];
  front_t             fr [ST_ENDPT];

  assign absd_in[0] = abs32(dir_x);
  assign absd_in[1] = abs32(dir_y);
  assign absd_in[2] = abs32(dir_z);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_pxz <= 64'(quat_x) * 64'(quat_z);
      s0_pwy <= 64'(quat_w) * 64'(quat_y);
      s0_pyz <= 64'(quat_y) * 64'(quat_z);
      s0_pwx <= 64'(quat_w) * 64'(quat_x);
      s0_pxx <= 64'(quat_x) * 64'(quat_x);
      s0_pyy <= 64'(quat_y) * 64'(quat_y);
      for (int i = 0; i < 3; i++) begin
        s0_sq[i] <= 64'(absd_in[i]) * 64'(absd_in[i]);
      end
      fr[0].dir  <= {dir_z, dir_y, dir_x};
      fr[0].pos  <= {pos_z, pos_y, pos_x};
      fr[0].core <= action;
      fr[0].zero <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
    end
  end

  for (genvar k = 1; k < ST_ENDPT; k++) begin : g_front
    always_ff @(posedge clk) begin
      if (en[k]) begin
        fr[k] <= fr[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: rotated axis (floor shifts, clamp to +-1.0) and squared length
  // ---------------------------------------------------------------------------
  logic signed [63:0] ax_sum [3];
  logic signed [31:0] s1_c [3];
  logic [63:0]        s1_l2;

  assign ax_sum[0] = (s0_pxz >>> 29) + (s0_pwy >>> 29);
  assign ax_sum[1] = (s0_pyz >>> 29) - (s0_pwx >>> 29);
  assign ax_sum[2] = csp_pkg::Q30_ONE - (s0_pxx >>> 29) - (s0_pyy >>> 29);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_c[i] <= clamp_q30(ax_sum[i]);
      end
      s1_l2 <= s0_sq[0] + s0_sq[1] + s0_sq[2];
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2..4: half-length offset and its projection on the direction
  // ---------------------------------------------------------------------------
  logic signed [63:0] s2_vp [3];
  logic signed [31:0] s3_v  [3];
  logic signed [31:0] s4_v  [3];
  logic signed [63:0] s4_vd [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_vp[i] <= 64'($signed({1'b0, half_length})) * 64'(s1_c[i]);
      end
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_v[i] <= 32'(s2_vp[i] >>> 30);
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_v[i]  <= s3_v[i];
        s4_vd[i] <= 64'(s3_v[i]) * 64'($signed(fr[3].dir[i]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: endpoint choice; plus end only on a strictly positive score
  // ---------------------------------------------------------------------------
  logic signed [63:0] score;
  logic               plus_end;
  side_t              sd [ST_ENDPT:ST_DIV_LAST];

  assign score    = (s4_vd[0] >>> 16) + (s4_vd[1] >>> 16) + (s4_vd[2] >>> 16);
  assign plus_end = score > 64'sd0;

  always_ff @(posedge clk) begin
    if (en[ST_ENDPT]) begin
      for (int i = 0; i < 3; i++) begin
        sd[ST_ENDPT].pt[i]   <= plus_end
          ? 33'($signed(fr[4].pos[i])) + 33'(s4_v[i])
          : 33'($signed(fr[4].pos[i])) - 33'(s4_v[i]);
        sd[ST_ENDPT].absd[i] <= abs32($signed(fr[4].dir[i]));
        sd[ST_ENDPT].dneg[i] <= fr[4].dir[i][31];
      end
      sd[ST_ENDPT].core <= fr[4].core;
      sd[ST_ENDPT].zero <= fr[4].zero;
    end
  end

  for (genvar k = ST_ENDPT + 1; k <= ST_DIV_LAST; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2..33: direction length, floor of the square root
  // ---------------------------------------------------------------------------
  logic [31:0] root;

  csp_isqrt u_isqrt (
    .clk      (clk),
    .en       (en[ST_SQRT_LAST:ST_SQRT0]),
    .radicand (s1_l2),
    .root     (root)
  );

  // ---------------------------------------------------------------------------
  // stage 34: radius times |dir| as dividend; stages 35..65: three divider lanes
  // for a nonzero direction the quotient never exceeds radius since each |dir| is at most the length
  // ---------------------------------------------------------------------------
  logic [61:0] s34_num [3];
  logic [31:0] s34_len;
  logic [30:0] quo [3];

  always_ff @(posedge clk) begin
    if (en[ST_DIVIN]) begin
      for (int i = 0; i < 3; i++) begin
        s34_num[i] <= 62'(64'(radius) * 64'(sd[ST_DIVIN-1].absd[i]));
      end
      s34_len <= root;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    csp_div u_div (
      .clk (clk),
      .en  (en[ST_DIV_LAST:ST_DIV0]),
      .num (s34_num[i]),
      .den (s34_len),
      .quo (quo[i])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 66: signed radius offset, add and saturate
  // core request or zero direction adds nothing
  // ---------------------------------------------------------------------------
  logic signed [33:0] offs [3];
  logic signed [31:0] res_pt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd[ST_DIV_LAST].zero || sd[ST_DIV_LAST].core) begin
        offs[i] = '0;
      end else if (sd[ST_DIV_LAST].dneg[i]) begin
        offs[i] = -$signed({3'b000, quo[i]});
      end else begin
        offs[i] = $signed({3'b000, quo[i]});
      end
      res_pt[i] = sat32(34'($signed(sd[ST_DIV_LAST].pt[i])) + offs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      point_x        <= res_pt[0];
      point_y        <= res_pt[1];
      point_z        <= res_pt[2];
      zero_direction <= sd[ST_DIV_LAST].zero;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // items in flight change only by requests taken and results delivered
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(vld) ==
      $countones($past(vld)) + int'($past(in_fire)) - int'($past(out_fire)))
    else $error("pipeline occupancy does not match the handshakes");

  // a zero direction scores zero, so the minus end is chosen
  a_zero_minus: assert property (@(posedge clk) disable iff (rst)
    vld[ST_ENDPT-1] && fr[4].zero |-> !plus_end)
    else $error("plus end chosen for a zero direction");

  // the radius offset magnitude never exceeds the radius
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    vld[ST_DIV_LAST] && !sd[ST_DIV_LAST].zero |->
      quo[0] <= radius && quo[1] <= radius && quo[2] <= radius)
    else $error("radius offset exceeds the radius");

  // a stalled result keeps its stage contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(zero_direction))
    else $error("stalled result changed");

endmodule

// ===== dv/capsule_support_point_core_test.sv =====
module capsule_support_point_core_test;

  // one query as it enters the block
  typedef struct {
    logic               action;
    logic signed [31:0] dir [3];
    logic signed [31:0] pos [3];
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } query_t;

  // one support point as it leaves the block
  typedef struct {
    logic signed [31:0] point [3];
    logic               zero_dir;
  } support_t;

  // holds the expected support points and a private copy of the two registers
  class support_checker;
    logic [30:0] radius_q;
    logic [30:0] half_len_q;
    support_t    expected_points[$];
    int          mismatches;

    function new();
      radius_q   = csp_pkg::RADIUS_RESET;
      half_len_q = csp_pkg::HALF_LENGTH_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [30:0] val);
      if (idx == csp_pkg::CFG_RADIUS) radius_q = val;
      else half_len_q = val;
    endfunction

    task report(string what, int idx, longint got, longint want);
      $display("mismatch %s[%0d]: got %0d expected %0d", what, idx, got, want);
      mismatches++;
    endtask

    // rotate the core segment, pick the endpoint, add the radius offset
    function support_t predict_support(query_t q);
      longint d[3], p[3], c[3], v[3], pt[3];
      longint w, x, y, z, s, len, r;
      longint unsigned l2, m, res, bit_v;
      support_t o;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = q.dir[i];
        p[i] = q.pos[i];
      end
      w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
      c[0] = ((x * z) >>> 29) + ((w * y) >>> 29);
      c[1] = ((y * z) >>> 29) - ((w * x) >>> 29);
      c[2] = csp_pkg::Q30_ONE - ((x * x) >>> 29) - ((y * y) >>> 29);
      for (int i = 0; i < 3; i++) begin
        if (c[i] > csp_pkg::Q30_ONE) c[i] = csp_pkg::Q30_ONE;
        if (c[i] < -csp_pkg::Q30_ONE) c[i] = -csp_pkg::Q30_ONE;
        v[i] = (longint'(half_len_q) * c[i]) >>> 30;
        s += (v[i] * d[i]) >>> 16;
      end
      // tie goes to the minus end
      for (int i = 0; i < 3; i++) pt[i] = (s > 0) ? p[i] + v[i] : p[i] - v[i];
      o.zero_dir = (d[0] == 0 && d[1] == 0 && d[2] == 0);
      if (!q.action && !o.zero_dir) begin
        l2 = 0;
        for (int i = 0; i < 3; i++) begin
          m = (d[i] < 0) ? -d[i] : d[i];
          l2 += m * m;
        end
        // bitwise integer square root
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > l2) bit_v >>= 2;
        while (bit_v != 0) begin
          if (l2 >= res + bit_v) begin
            l2 -= res + bit_v;
            res = (res >> 1) + bit_v;
          end else begin
            res >>= 1;
          end
          bit_v >>= 2;
        end
        len = res;
        if (len > 0)
          for (int i = 0; i < 3; i++) pt[i] += (longint'(radius_q) * d[i]) / len;
      end
      for (int i = 0; i < 3; i++) begin
        r = pt[i];
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        o.point[i] = r[31:0];
      end
      return o;
    endfunction

    function void note_query(query_t q);
      expected_points.insert(expected_points.size(), predict_support(q));
    endfunction

    task check_point(support_t got);
      support_t want;
      if (expected_points.size() == 0) begin
        $display("unexpected support point with nothing pending");
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        for (int i = 0; i < 3; i++)
          if (got.point[i] !== want.point[i]) report("point", i, got.point[i], want.point[i]);
        if (got.zero_dir !== want.zero_dir) report("zero_direction", 0, got.zero_dir,
                                                   want.zero_dir);
      end
    endtask
  endclass

  localparam int LATENCY  = 67;
  localparam int WATCHDOG = 3000;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [30:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic signed [31:0] dir_x, dir_y, dir_z;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] point_x, point_y, point_z;
  logic               zero_direction;

  support_checker board;
  int             idle_cycles;
  bit             stimulus_done;

  capsule_support_point_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // scoreboard hooks, sampled on the rising edge
  always @(posedge clk) begin
    support_t got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        query_t q;
        q.action = action;
        q.dir[0] = dir_x; q.dir[1] = dir_y; q.dir[2] = dir_z;
        q.pos[0] = pos_x; q.pos[1] = pos_y; q.pos[2] = pos_z;
        q.quat_w = quat_w; q.quat_x = quat_x; q.quat_y = quat_y; q.quat_z = quat_z;
        board.note_query(q);
      end
      if (out_valid && out_ready) begin
        got.point[0] = point_x; got.point[1] = point_y; got.point[2] = point_z;
        got.zero_dir = zero_direction;
        board.check_point(got);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no handshake for %0d cycles", idle_cycles);
      $display("capsule_support_point_core regression: fail");
      $finish;
    end
  end

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // result side stalls at random
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int g;
      out_ready = 1'b1;
      repeat ($urandom_range(30, 1)) @(negedge clk);
      g = ($urandom_range(4) == 0) ? 0 : pick_gap();
      if (g > 0) begin
        out_ready = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [30:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // block goes idle: all expected points in, then the pipeline drains
  task automatic drain();
    while (board.expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // drive one request and hold it until accepted; called at a falling edge
  task automatic send_query(query_t q, bit gaps);
    int g;
    action = q.action;
    dir_x = q.dir[0]; dir_y = q.dir[1]; dir_z = q.dir[2];
    pos_x = q.pos[0]; pos_y = q.pos[1]; pos_z = q.pos[2];
    quat_w = q.quat_w; quat_x = q.quat_x; quat_y = q.quat_y; quat_z = q.quat_z;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  function automatic logic signed [31:0] rand_q30();
    return int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  // mix of full range, small values and exact zero
  function automatic logic signed [31:0] rand_coord();
    int k;
    k = $urandom_range(9);
    if (k < 3) return rand_word();
    if (k < 9) return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    return 0;
  endfunction

  // component from the set that builds exact unit rotations
  function automatic logic signed [31:0] rot_part(int sel);
    logic signed [31:0] mag;
    case (sel)
      0: mag = 32'sd1073741824;
      1: mag = 32'sd759250125;
      default: mag = 32'sd536870912;
    endcase
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic query_t make_query();
    query_t q;
    int kind, ax;
    q.action = 1'($urandom_range(1));
    for (int i = 0; i < 3; i++) begin
      q.dir[i] = rand_coord();
      q.pos[i] = rand_coord();
    end
    if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) q.dir[i] = 0;
    kind = $urandom_range(9);
    q.quat_w = 0; q.quat_x = 0; q.quat_y = 0; q.quat_z = 0;
    ax = $urandom_range(3);
    case (kind)
      0, 1: q.quat_w = rot_part(0);
      2, 3: begin
        q.quat_w = rot_part(1);
        case (ax)
          0: q.quat_x = rot_part(1);
          1: q.quat_y = rot_part(1);
          default: q.quat_z = rot_part(1);
        endcase
      end
      4, 5: begin
        case (ax)
          0: q.quat_x = rot_part(0);
          1: q.quat_y = rot_part(0);
          default: q.quat_z = rot_part(0);
        endcase
      end
      6: begin
        q.quat_w = rot_part(2); q.quat_x = rot_part(2);
        q.quat_y = rot_part(2); q.quat_z = rot_part(2);
      end
      default: begin
        // non-unit quaternion, exercises the axis clamp
        q.quat_w = rand_q30(); q.quat_x = rand_q30();
        q.quat_y = rand_q30(); q.quat_z = rand_q30();
      end
    endcase
    return q;
  endfunction

  function automatic query_t plain_query(logic act, int dx, int dy, int dz,
                                         int qw, int qx, int qy, int qz);
    query_t q;
    q.action = act;
    q.dir[0] = dx; q.dir[1] = dy; q.dir[2] = dz;
    q.pos[0] = 0; q.pos[1] = 0; q.pos[2] = 0;
    q.quat_w = qw; q.quat_x = qx; q.quat_y = qy; q.quat_z = qz;
    return q;
  endfunction

  initial begin
    query_t q;
    logic [30:0] radius_set [4];
    logic [30:0] half_set [4];
    board = new();
    stimulus_done = 0;
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = csp_pkg::CFG_RADIUS; cfg_data = '0;
    in_valid = 1'b0; action = 1'b0;
    dir_x = 0; dir_y = 0; dir_z = 0;
    pos_x = 0; pos_y = 0; pos_z = 0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at reset values
    // zero direction in both actions, returns the minus end
    send_query(plain_query(1'b0, 0, 0, 0, 32'sh4000_0000, 0, 0, 0), 0);
    send_query(plain_query(1'b1, 0, 0, 0, 32'sh4000_0000, 0, 0, 0), 0);
    // tie: a direction perpendicular to the segment keeps the minus end, then directions along and against it
    send_query(plain_query(1'b0, 32'sh0001_0000, 0, 0, 32'sh4000_0000, 0, 0, 0), 0);
    send_query(plain_query(1'b0, 0, 0, 32'sh0001_0000, 32'sh4000_0000, 0, 0, 0), 0);
    send_query(plain_query(1'b1, 0, 0, -32'sh0001_0000, 32'sh4000_0000, 0, 0, 0), 0);
    // extreme directions, unclamped rotations by 180 degrees about each axis, and a negated identity quaternion
    send_query(plain_query(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           0, 32'sh4000_0000, 0, 0), 0);
    send_query(plain_query(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                           0, 0, 32'sh4000_0000, 0), 0);
    send_query(plain_query(1'b1, 32'sh8000_0000, 1, -1, 0, 0, 0, 32'sh4000_0000), 0);
    send_query(plain_query(1'b0, 1, 0, 0, -32'sh4000_0000, 0, 0, 0), 0);
    // non-unit quaternions at the range ends hit the axis clamp
    send_query(plain_query(1'b0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                           32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000), 0);
    send_query(plain_query(1'b1, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000,
                           -32'sh4000_0000, 32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000), 0);
    // saturation at both ends of the position range
    q = plain_query(1'b0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    32'sh4000_0000, 0, 0, 0);
    q.pos[0] = 32'sh7fff_ffff; q.pos[1] = 32'sh7fff_ffff; q.pos[2] = 32'sh7fff_ffff;
    send_query(q, 0);
    q = plain_query(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh4000_0000, 0, 0, 0);
    q.pos[0] = 32'sh8000_0000; q.pos[1] = 32'sh8000_0000; q.pos[2] = 32'sh8000_0000;
    send_query(q, 0);
    in_valid = 1'b0;

    // register settings, extremes among them, then the reset values again and a random pair
    radius_set = '{31'h7fff_ffff, 31'd0, 31'd3 << 16, csp_pkg::RADIUS_RESET};
    half_set   = '{31'h7fff_ffff, 31'd0, 31'd5 << 15, csp_pkg::HALF_LENGTH_RESET};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      if (ph < 4) begin
        write_reg(csp_pkg::CFG_RADIUS, radius_set[ph]);
        write_reg(csp_pkg::CFG_HALF_LENGTH, half_set[ph]);
      end else begin
        write_reg(csp_pkg::CFG_RADIUS, 31'($urandom()));
        write_reg(csp_pkg::CFG_HALF_LENGTH, 31'($urandom()));
      end
      @(negedge clk);
      for (int n = 0; n < 250; n++) begin
        send_query(make_query(), 1);
        // sender holds off once until every point is back
        if (ph == 2 && n == 120) begin
          in_valid = 1'b0;
          while (board.expected_points.size() != 0) @(negedge clk);
        end
      end
      in_valid = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0) $display("capsule_support_point_core regression: pass");
    else $display("capsule_support_point_core regression: fail");
    $finish;
  end

endmodule

// ===== capsule_support_point_core.f =====
rtl/csp_pkg.sv
rtl/csp_isqrt.sv
rtl/csp_div.sv
rtl/capsule_support_point_core.sv
dv/capsule_support_point_core_test.sv
